@@ rtl/swfs_pkg.sv @@
// swfs_pkg: shared constants and request codes for the frame statistics block
// no dependencies; used by sliding_window_frame_stats
`default_nettype none
package swfs_pkg;

	// default sizes handed to the top level parameters
	localparam int CAPACITY_DEF   = 256;
	localparam int STAMP_BITS_DEF = 48;

	// field and register widths
	localparam int REQ_W      = 2;
	localparam int NOW_W      = 48;
	localparam int FT_W       = 32;
	localparam int CW_W       = 9;
	localparam int SPAN_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int AVG_W      = 32;
	localparam int FPS_W      = 40;
	localparam int OUT_N_W    = 9;

	// time scale constants
	localparam int SPAN_NS_W = 36;
	localparam int MS_W      = 20;
	localparam int SEC_W     = 30;
	localparam logic [MS_W-1:0]  NS_PER_MS = 20'd1000000;
	localparam logic [SEC_W-1:0] NS_PER_S  = 30'd1000000000;
	localparam int Q8_SHIFT  = 8;
	localparam int Q8_W      = SEC_W + Q8_SHIFT;
	localparam logic [FPS_W-1:0] FPS_MAX = 40'hFF_FFFF_FFFF;

	// register reset values
	localparam logic [CW_W-1:0]   COUNT_WINDOW_RST = 9'd60;
	localparam logic [SPAN_W-1:0] SPAN_WINDOW_RST  = 16'd1000;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SNAP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_WINDOW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_WINDOW  = 1'b1;

endpackage
`default_nettype wire

@@ rtl/sliding_window_frame_stats.sv @@
// sliding_window_frame_stats: ring of frame samples with count and time window statistics
// depends on swfs_pkg, swfs_ram (stamp and duration stores) and swfs_div
//
// channel   signals                                   direction  transfer when
// request   req_valid req_stall req_type now_ns ...   in         req_valid && !req_stall
// result    res_valid res_stall accepted count_n ...  out        res_valid && !res_stall
// config    cfg_we cfg_index cfg_data                 in         cfg_we
//
// one request at a time; req_stall is high from the transfer until the result is loaded
// steps after a request transfer: decode, then a stored add prunes, stopping when the count
// window keeps the oldest sample or else when the time test does, with a read and a check
// per pruned sample; add refused, clear and unused code go from decode to the result
// snapshot: prune as add, then a ring scan over the held samples, then four division
// jobs in issue order, each skipped when its count or elapsed time leaves nothing to divide
// the result register frees the block while a result waits under res_stall; the next
// request then holds in its last state until that result transfers
// no clearing pass after reset: only entries that hold samples are read
`default_nettype none
module sliding_window_frame_stats #(
	parameter int CAPACITY   = swfs_pkg::CAPACITY_DEF,
	parameter int STAMP_BITS = swfs_pkg::STAMP_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request channel
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic [swfs_pkg::REQ_W-1:0]        req_type,
	input  wire logic [swfs_pkg::NOW_W-1:0]        now_ns,
	input  wire logic [swfs_pkg::FT_W-1:0]         frame_time_ns,
	// result channel
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	output logic                                   accepted,
	output logic      [swfs_pkg::OUT_N_W-1:0]      count_n,
	output logic      [swfs_pkg::AVG_W-1:0]        count_avg_ns,
	output logic      [swfs_pkg::FPS_W-1:0]        count_fps_q8,
	output logic      [swfs_pkg::OUT_N_W-1:0]      span_n,
	output logic      [swfs_pkg::AVG_W-1:0]        span_avg_ns,
	output logic      [swfs_pkg::FPS_W-1:0]        span_fps_q8,
	// configuration port
	input  wire logic                              cfg_we,
	input  wire logic [swfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [swfs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// derived sizes
	localparam int AW     = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int SUM_W  = swfs_pkg::FT_W + CNT_W;
	localparam int FNUM_W = CNT_W + swfs_pkg::Q8_W;
	localparam int NUM_W  = (SUM_W > FNUM_W) ? SUM_W : FNUM_W;
	localparam int DEN_W  = (CNT_W > STAMP_BITS) ? CNT_W : STAMP_BITS;
	localparam int CMP_W  = (STAMP_BITS > swfs_pkg::SPAN_NS_W) ? STAMP_BITS
	                        : swfs_pkg::SPAN_NS_W;
	localparam int MX_W   = (CNT_W > swfs_pkg::CW_W) ? CNT_W : swfs_pkg::CW_W;
	localparam int PR_W   = CNT_W + swfs_pkg::SEC_W;

	// sequencer states
	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DECODE   = 8'b0000_0010,
		S_PR_RD    = 8'b0000_0100,
		S_PR_CK    = 8'b0000_1000,
		S_SCAN     = 8'b0001_0000,
		S_DIV_GO   = 8'b0010_0000,
		S_DIV_WAIT = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	// division jobs, in issue order
	typedef enum logic [1:0] {
		JOB_CAVG = 2'd0,
		JOB_CFPS = 2'd1,
		JOB_SAVG = 2'd2,
		JOB_SFPS = 2'd3
	} job_t;

	// ring index add modulo capacity; both operands stay below capacity + 1
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a,
	                                       input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (s >= (CNT_W+1)'(CAPACITY)) begin
			s = s - (CNT_W+1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [swfs_pkg::FPS_W-1:0] sat_fps(input logic [NUM_W-1:0] q);
		if (q > NUM_W'(swfs_pkg::FPS_MAX)) begin
			return swfs_pkg::FPS_MAX;
		end
		return q[swfs_pkg::FPS_W-1:0];
	endfunction

	// control state
	state_t                        state_q;
	job_t                          job_q;
	logic [AW-1:0]                 oldest_q;
	logic [CNT_W-1:0]              held_q;
	logic [STAMP_BITS-1:0]         last_q;
	logic                          has_last_q;
	logic [swfs_pkg::CW_W-1:0]     cw_q;
	logic [swfs_pkg::SPAN_W-1:0]   span_q;
	logic [CNT_W-1:0]              i_q;
	logic                          v_s1;
	logic                          res_valid_q;

	// request and working data
	logic [swfs_pkg::REQ_W-1:0]    req_q;
	logic [STAMP_BITS-1:0]         now_q;
	logic [swfs_pkg::FT_W-1:0]     ft_q;
	logic [swfs_pkg::SPAN_NS_W-1:0] span_ns_q;
	logic [STAMP_BITS-1:0]         cutoff_q;
	logic [CNT_W-1:0]              i_s1;
	logic [CNT_W-1:0]              n_c_q;
	logic [CNT_W-1:0]              cstart_q;
	logic [CNT_W-1:0]              n_s_q;
	logic [SUM_W-1:0]              c_sum_q;
	logic [SUM_W-1:0]              s_sum_q;
	logic [STAMP_BITS-1:0]         c_first_q;
	logic [STAMP_BITS-1:0]         c_last_q;
	logic [STAMP_BITS-1:0]         s_first_q;
	logic [STAMP_BITS-1:0]         s_last_q;
	logic                          acc_q;
	logic [swfs_pkg::AVG_W-1:0]    cavg_q;
	logic [swfs_pkg::AVG_W-1:0]    savg_q;
	logic [swfs_pkg::FPS_W-1:0]    cfps_q;
	logic [swfs_pkg::FPS_W-1:0]    sfps_q;

	// memory ports
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [AW-1:0]                 mem_raddr;
	logic [STAMP_BITS-1:0]         stamp_rd;
	logic [swfs_pkg::FT_W-1:0]     dur_rd;

	// divider
	logic                          div_start;
	logic [NUM_W-1:0]              div_num;
	logic [DEN_W-1:0]              div_den;
	logic                          div_done;
	logic [NUM_W-1:0]              div_quo;
	logic                          job_skip;

	// decode helpers
	logic                          req_xfer;
	logic                          full;
	logic                          add_reject;
	logic [CMP_W-1:0]              now_x;
	logic [CMP_W-1:0]              span_x;
	logic [STAMP_BITS-1:0]         cutoff_d;
	logic [MX_W-1:0]               cw_x;
	logic [MX_W-1:0]               held_x;
	logic                          keep_count;
	logic [CNT_W-1:0]              n_c_d;
	logic                          in_c;
	logic                          in_s;
	logic [STAMP_BITS-1:0]         c_elapsed;
	logic [STAMP_BITS-1:0]         s_elapsed;
	logic [PR_W-1:0]               c_prod;
	logic [PR_W-1:0]               s_prod;
	logic                          res_free;

	assign req_xfer  = req_valid && !req_stall;
	assign req_stall = state_q != S_IDLE;
	assign res_free  = !res_valid_q || !res_stall;

	assign full       = held_q == CNT_W'(CAPACITY);
	assign add_reject = (ft_q == '0) || ((cw_q == '0) && (span_q == '0))
	                    || (has_last_q && (now_q < last_q));

	// cutoff is now minus span, floored at zero
	assign now_x    = CMP_W'(now_q);
	assign span_x   = CMP_W'(span_ns_q);
	assign cutoff_d = (now_x >= span_x) ? STAMP_BITS'(now_x - span_x) : '0;

	// count window keeps the oldest sample while the store fits in it
	assign cw_x       = MX_W'(cw_q);
	assign held_x     = MX_W'(held_q);
	assign keep_count = (cw_x != '0) && (held_x <= cw_x);
	assign n_c_d      = (cw_x == '0) ? '0 : ((cw_x < held_x) ? CNT_W'(cw_x) : held_q);

	// window membership of the sample read in the cycle before
	assign in_c = (n_c_q != '0) && (i_s1 >= cstart_q);
	assign in_s = (span_q != '0) && (stamp_rd >= cutoff_q) && (stamp_rd <= now_q);

	// stores: write on accepted add, read oldest while pruning, walk the ring on scan
	assign mem_we    = (state_q == S_DECODE) && (req_q == swfs_pkg::REQ_ADD) && !add_reject;
	assign mem_waddr = full ? oldest_q : wrap(oldest_q, held_q);
	assign mem_raddr = (state_q == S_SCAN) ? wrap(oldest_q, i_q) : oldest_q;

	swfs_ram #(
		.WIDTH (STAMP_BITS),
		.DEPTH (CAPACITY)
	) u_stamp_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (now_q),
		.raddr (mem_raddr),
		.rdata (stamp_rd)
	);

	swfs_ram #(
		.WIDTH (swfs_pkg::FT_W),
		.DEPTH (CAPACITY)
	) u_dur_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (ft_q),
		.raddr (mem_raddr),
		.rdata (dur_rd)
	);

	// division operands; rate numerator is n * 1e9 * 256
	assign c_elapsed = c_last_q - c_first_q;
	assign s_elapsed = s_last_q - s_first_q;
	assign c_prod    = PR_W'(n_c_q) * PR_W'(swfs_pkg::NS_PER_S);
	assign s_prod    = PR_W'(n_s_q) * PR_W'(swfs_pkg::NS_PER_S);

	always_comb begin
		job_skip = 1'b0;
		div_num  = '0;
		div_den  = '0;
		unique case (job_q)
			JOB_CAVG: begin
				job_skip = n_c_q == '0;
				div_num  = NUM_W'(c_sum_q);
				div_den  = DEN_W'(n_c_q);
			end
			JOB_CFPS: begin
				job_skip = (n_c_q < CNT_W'(2)) || (c_elapsed == '0);
				div_num  = NUM_W'({c_prod, {swfs_pkg::Q8_SHIFT{1'b0}}});
				div_den  = DEN_W'(c_elapsed);
			end
			JOB_SAVG: begin
				job_skip = n_s_q == '0;
				div_num  = NUM_W'(s_sum_q);
				div_den  = DEN_W'(n_s_q);
			end
			JOB_SFPS: begin
				job_skip = (n_s_q < CNT_W'(2)) || (s_elapsed == '0);
				div_num  = NUM_W'({s_prod, {swfs_pkg::Q8_SHIFT{1'b0}}});
				div_den  = DEN_W'(s_elapsed);
			end
			default: begin
				job_skip = 1'b1;
			end
		endcase
	end

	assign div_start = (state_q == S_DIV_GO) && !job_skip;

	swfs_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= JOB_CAVG;
			oldest_q    <= '0;
			held_q      <= '0;
			last_q      <= '0;
			has_last_q  <= 1'b0;
			cw_q        <= swfs_pkg::COUNT_WINDOW_RST;
			span_q      <= swfs_pkg::SPAN_WINDOW_RST;
			i_q         <= '0;
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// the user must write config only while no request is in flight; the block does not enforce it
			if (cfg_we) begin
				unique case (cfg_index)
					swfs_pkg::REG_COUNT_WINDOW: cw_q   <= cfg_data[swfs_pkg::CW_W-1:0];
					swfs_pkg::REG_SPAN_WINDOW:  span_q <= cfg_data;
					default: ;
				endcase
			end

			// result register loads at the end of a request, empties on its transfer
			if ((state_q == S_DONE) && res_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					priority if (req_q == swfs_pkg::REQ_ADD) begin
						if (add_reject) begin
							state_q <= S_DONE;
						end else begin
							// full store drops its oldest sample before the append
							if (full) begin
								oldest_q <= wrap(oldest_q, CNT_W'(1));
							end else begin
								held_q <= held_q + CNT_W'(1);
							end
							last_q     <= now_q;
							has_last_q <= 1'b1;
							state_q    <= S_PR_RD;
						end
					end else if (req_q == swfs_pkg::REQ_SNAP) begin
						state_q <= S_PR_RD;
					end else if (req_q == swfs_pkg::REQ_CLEAR) begin
						held_q     <= '0;
						oldest_q   <= '0;
						last_q     <= '0;
						has_last_q <= 1'b0;
						state_q    <= S_DONE;
					end else begin
						// unused code: no effect
						state_q <= S_DONE;
					end
				end
				S_PR_RD: begin
					if ((held_q == '0) || keep_count) begin
						if (req_q == swfs_pkg::REQ_SNAP) begin
							i_q     <= '0;
							v_s1    <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_PR_CK;
					end
				end
				S_PR_CK: begin
					if ((span_q != '0) && (stamp_rd >= cutoff_q)) begin
						if (req_q == swfs_pkg::REQ_SNAP) begin
							i_q     <= '0;
							v_s1    <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						oldest_q <= wrap(oldest_q, CNT_W'(1));
						held_q   <= held_q - CNT_W'(1);
						state_q  <= S_PR_RD;
					end
				end
				S_SCAN: begin
					// one ring entry read per cycle, checked the cycle after
					if (i_q < held_q) begin
						v_s1 <= 1'b1;
						i_q  <= i_q + CNT_W'(1);
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							job_q   <= JOB_CAVG;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_DIV_GO: begin
					if (!job_skip) begin
						state_q <= S_DIV_WAIT;
					end else if (job_q == JOB_SFPS) begin
						state_q <= S_DONE;
					end else begin
						job_q <= job_t'(job_q + 2'd1);
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						if (job_q == JOB_SFPS) begin
							state_q <= S_DONE;
						end else begin
							job_q   <= job_t'(job_q + 2'd1);
							state_q <= S_DIV_GO;
						end
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, window accumulators, statistics and result payload
	always_ff @(posedge clk) begin
		span_ns_q <= swfs_pkg::SPAN_NS_W'(span_q) * swfs_pkg::SPAN_NS_W'(swfs_pkg::NS_PER_MS);

		if (req_xfer) begin
			req_q <= req_type;
			now_q <= STAMP_BITS'(now_ns);
			ft_q  <= frame_time_ns;
		end

		if (state_q == S_DECODE) begin
			cutoff_q <= cutoff_d;
			acc_q    <= (req_q == swfs_pkg::REQ_SNAP) || (req_q == swfs_pkg::REQ_CLEAR)
			            || ((req_q == swfs_pkg::REQ_ADD) && !add_reject);
			n_c_q    <= '0;
			n_s_q    <= '0;
			cavg_q   <= '0;
			savg_q   <= '0;
			cfps_q   <= '0;
			sfps_q   <= '0;
		end

		// window setup at the end of the prune; an add reports no statistics
		if ((state_q == S_PR_RD) || (state_q == S_PR_CK)) begin
			n_c_q    <= (req_q == swfs_pkg::REQ_SNAP) ? n_c_d : '0;
			cstart_q <= held_q - n_c_d;
			n_s_q    <= '0;
			c_sum_q  <= '0;
			s_sum_q  <= '0;
		end

		if (state_q == S_SCAN) begin
			i_s1 <= i_q;
			if (v_s1) begin
				if (in_c) begin
					c_sum_q <= c_sum_q + SUM_W'(dur_rd);
					if (i_s1 == cstart_q) begin
						c_first_q <= stamp_rd;
					end
					c_last_q <= stamp_rd;
				end
				if (in_s) begin
					s_sum_q <= s_sum_q + SUM_W'(dur_rd);
					if (n_s_q == '0) begin
						s_first_q <= stamp_rd;
					end
					s_last_q <= stamp_rd;
					n_s_q    <= n_s_q + CNT_W'(1);
				end
			end
		end

		if ((state_q == S_DIV_WAIT) && div_done) begin
			unique case (job_q)
				JOB_CAVG: cavg_q <= div_quo[swfs_pkg::AVG_W-1:0];
				JOB_CFPS: cfps_q <= sat_fps(div_quo);
				JOB_SAVG: savg_q <= div_quo[swfs_pkg::AVG_W-1:0];
				JOB_SFPS: sfps_q <= sat_fps(div_quo);
				default: ;
			endcase
		end

		if ((state_q == S_DONE) && res_free) begin
			accepted     <= acc_q;
			count_n      <= swfs_pkg::OUT_N_W'(n_c_q);
			count_avg_ns <= cavg_q;
			count_fps_q8 <= cfps_q;
			span_n       <= swfs_pkg::OUT_N_W'(n_s_q);
			span_avg_ns  <= savg_q;
			span_fps_q8  <= sfps_q;
		end
	end

	assign res_valid = res_valid_q;

endmodule
`default_nettype wire

@@ rtl/swfs_ram.sv @@
// swfs_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module swfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/swfs_div.sv @@
// swfs_div: restoring divider, one quotient bit per cycle
// no dependencies; quotient is valid while done is high
`default_nettype none
module swfs_div #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 48
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/swfs_checker.sv @@
// swfs_checker: port level checks on the frame statistics block
// no dependencies; bound to sliding_window_frame_stats below
`default_nettype none
module swfs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic        accepted,
	input wire logic [8:0]  count_n,
	input wire logic [31:0] count_avg_ns,
	input wire logic [39:0] count_fps_q8,
	input wire logic [8:0]  span_n,
	input wire logic [31:0] span_avg_ns,
	input wire logic [39:0] span_fps_q8
);

	// a stalled result stays
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(count_n) && $stable(span_n))
		else $error("result dropped under stall");

	// one request at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// rejected or unused requests carry no statistics
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !accepted |-> count_n == 9'd0 && span_n == 9'd0
			&& count_avg_ns == 32'd0 && span_avg_ns == 32'd0
			&& count_fps_q8 == 40'd0 && span_fps_q8 == 40'd0)
		else $error("statistics on rejected request");

	// no count rate below two samples
	a_rate_min: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && count_n < 9'd2 |-> count_fps_q8 == 40'd0)
		else $error("count rate with fewer than two samples");

	// empty time window reports nothing
	a_span_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && span_n == 9'd0 |-> span_avg_ns == 32'd0 && span_fps_q8 == 40'd0)
		else $error("statistics on empty time window");

endmodule

bind sliding_window_frame_stats swfs_checker u_swfs_checker (.*);
`default_nettype wire
